// File: src/face_normal_unit_core_defines.svh
// assertion macros for the face normal core
`ifndef FACE_NORMAL_UNIT_CORE_DEFINES_SVH
`define FACE_NORMAL_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FNU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define FNU_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define FNU_ASSERT_IMP(name, clk, rst, ante, cons)
`define FNU_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: src/fnu_pkg.sv
`default_nettype none

package fnu_pkg;

   localparam int COORD_W    = 16;
   localparam int IDX_W      = 12;
   localparam int NORM_W     = 16;
   localparam int LIMIT_W    = 16;
   localparam int EDGE_W     = 17;
   localparam int PROD_W     = 34;
   localparam int MAG_W      = 33;
   localparam int SMALL_W    = 16;
   localparam int SHIFT_W    = 6;
   localparam int SMAG_W     = 30;
   localparam int SQ_W       = 60;
   localparam int SUM_W      = 62;
   localparam int ROOT_STEPS = 31;
   localparam int LEN_W      = 31;
   localparam int FRAC_W     = 14;
   localparam int QUO_W      = 15;
   localparam int NUM_W      = 46;

   localparam logic signed [NORM_W-1:0] UNIT_ONE = 16'sd16384;
   localparam logic [LIMIT_W-1:0] MIN_LENGTH_RESET = 16'd1;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FACE  = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      op_type                    operation;
      logic [IDX_W-1:0]          vertex_slot;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [IDX_W-1:0]          corner_a;
      logic [IDX_W-1:0]          corner_b;
      logic [IDX_W-1:0]          corner_c;
      logic [IDX_W-1:0]          face_number;
      logic                      last_face;
   } req_payload_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
      logic [IDX_W-1:0]         face_out;
      logic                     last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] face;
      logic             last;
   } tag_type;

   typedef struct packed {
      tag_type    tag;
      logic       degen;
      logic [2:0] neg;
   } norm_side_type;

   typedef logic [2:0][MAG_W-1:0]  mag_vec_type;
   typedef logic [2:0][SMAG_W-1:0] smag_vec_type;
   typedef logic [2:0][QUO_W-1:0]  quo_vec_type;

endpackage

`default_nettype wire

// File: src/fnu_stream_if.sv
`default_nettype none

interface fnu_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/face_normal_unit_core.sv
// Triangle face normal core.
// Requests arrive on req_chan (valid/ready). A request with operation write
// stores one Q8.8 vertex in the vertex store and gives no response. A face
// request reads corners a, b and c together from three copies of the
// store, forms (a-b) x (c-b), tests its length against min_length and gives
// one response on rsp_chan: a Q1.14 unit normal, or (0,0,1) with degenerate
// set. The csr port writes min_length (reset value 1); the user must write
// it only while the core is idle, as the core does not enforce this. One
// request is taken every cycle while the skid buffer is empty. A face
// request passes the 31-step square root pipeline and the 15-step dividers
// behind it. A write is visible to a face request taken in the next cycle.
// Responses leave through an output register backed by a one-entry skid
// buffer: while the receiver stalls, the pipeline still advances until the
// skid buffer fills, then req_chan.ready drops and everything holds.
// Reset clears the pipeline and the output stages and sets min_length to 1;
// the vertex store holds unknown values until written and is not cleared.
`default_nettype none

`include "face_normal_unit_core_defines.svh"

module face_normal_unit_core #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   fnu_stream_if.sink                         req_chan,
   fnu_stream_if.source                       rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [fnu_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam int ADDR_W  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int IW      = fnu_pkg::IDX_W;
   localparam int EXT_W   = (ADDR_W > IW) ? ADDR_W : IW;
   localparam int VW      = $bits(fnu_pkg::vertex_type);
   localparam int QW      = fnu_pkg::QUO_W;
   localparam int OW      = fnu_pkg::NORM_W;
   localparam logic [QW-1:0] QUO_LIMIT = QW'(fnu_pkg::UNIT_ONE);

   fnu_pkg::req_payload_type req_pl;
   logic                     en;
   logic                     req_fire;
   logic [fnu_pkg::LIMIT_W-1:0] min_length_ff;

   logic [EXT_W-1:0]  slot_ext;
   logic [EXT_W-1:0]  a_ext;
   logic [EXT_W-1:0]  b_ext;
   logic [EXT_W-1:0]  c_ext;
   logic              wr_en;
   logic [2:0]        inr_in;
   logic [VW-1:0]     wr_data;
   logic [VW-1:0]     q_a;
   logic [VW-1:0]     q_b;
   logic [VW-1:0]     q_c;

   logic              s1_v_ff;
   fnu_pkg::tag_type  s1_tag_ff;
   fnu_pkg::tag_type  s1_tag_in;
   logic [2:0]        s1_inr_ff;
   fnu_pkg::vertex_type vert_a;
   fnu_pkg::vertex_type vert_b;
   fnu_pkg::vertex_type vert_c;

   logic                   cr_valid;
   fnu_pkg::tag_type       cr_tag;
   fnu_pkg::mag_vec_type   cr_mag;
   logic [2:0]             cr_neg;
   logic                   sc_valid;
   fnu_pkg::norm_side_type sc_side;
   fnu_pkg::smag_vec_type  sc_smag;
   logic [fnu_pkg::SUM_W-1:0] sc_sum;
   logic                   rt_valid;
   fnu_pkg::norm_side_type rt_side;
   fnu_pkg::smag_vec_type  rt_smag;
   logic [fnu_pkg::LEN_W-1:0] rt_len;
   logic                   dv_valid;
   fnu_pkg::norm_side_type dv_side;
   fnu_pkg::quo_vec_type   dv_quo;

   fnu_pkg::rsp_payload_type pipe_d;
   logic                     pipe_v;
   logic                     take;
   logic                     out_v_ff;
   logic                     out_v_in;
   fnu_pkg::rsp_payload_type out_d_ff;
   fnu_pkg::rsp_payload_type out_d_in;
   logic                     skid_v_ff;
   logic                     skid_v_in;
   fnu_pkg::rsp_payload_type skid_d_ff;
   fnu_pkg::rsp_payload_type skid_d_in;

   // whole pipeline advances unless the skid buffer is holding a response
   assign en             = !skid_v_ff;
   assign req_chan.ready = en;
   assign req_pl         = req_chan.payload;
   assign req_fire       = req_chan.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= fnu_pkg::MIN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         min_length_ff <= csr_wr_data;
      end
   end

   // vertex store: three copies written together, one read port each
   assign slot_ext  = EXT_W'(req_pl.vertex_slot);
   assign a_ext     = EXT_W'(req_pl.corner_a);
   assign b_ext     = EXT_W'(req_pl.corner_b);
   assign c_ext     = EXT_W'(req_pl.corner_c);
   assign wr_data   = {req_pl.pos_x, req_pl.pos_y, req_pl.pos_z};
   assign wr_en     = req_fire && (req_pl.operation == fnu_pkg::OP_WRITE)
                      && (32'(req_pl.vertex_slot) < 32'(VERTEX_DEPTH));
   assign inr_in[0] = 32'(req_pl.corner_a) < 32'(VERTEX_DEPTH);
   assign inr_in[1] = 32'(req_pl.corner_b) < 32'(VERTEX_DEPTH);
   assign inr_in[2] = 32'(req_pl.corner_c) < 32'(VERTEX_DEPTH);

   fnu_ram #(.DATA_W(VW), .DEPTH(VERTEX_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (a_ext[ADDR_W-1:0]),
      .rd_data (q_a)
   );

   fnu_ram #(.DATA_W(VW), .DEPTH(VERTEX_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (b_ext[ADDR_W-1:0]),
      .rd_data (q_b)
   );

   fnu_ram #(.DATA_W(VW), .DEPTH(VERTEX_DEPTH)) u_ram_c (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (c_ext[ADDR_W-1:0]),
      .rd_data (q_c)
   );

   assign s1_tag_in.face = req_pl.face_number;
   assign s1_tag_in.last = req_pl.last_face;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_fire && (req_pl.operation == fnu_pkg::OP_FACE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= s1_tag_in;
         s1_inr_ff <= inr_in;
      end
   end

   // corners outside the store read as the origin
   assign vert_a = s1_inr_ff[0] ? fnu_pkg::vertex_type'(q_a) : '0;
   assign vert_b = s1_inr_ff[1] ? fnu_pkg::vertex_type'(q_b) : '0;
   assign vert_c = s1_inr_ff[2] ? fnu_pkg::vertex_type'(q_c) : '0;

   fnu_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_v_ff),
      .in_tag    (s1_tag_ff),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .out_valid (cr_valid),
      .out_tag   (cr_tag),
      .out_mag   (cr_mag),
      .out_neg   (cr_neg)
   );

   fnu_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (cr_valid),
      .in_tag     (cr_tag),
      .in_mag     (cr_mag),
      .in_neg     (cr_neg),
      .min_length (min_length_ff),
      .out_valid  (sc_valid),
      .out_side   (sc_side),
      .out_smag   (sc_smag),
      .out_sum    (sc_sum)
   );

   fnu_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid),
      .in_side   (sc_side),
      .in_smag   (sc_smag),
      .in_sum    (sc_sum),
      .out_valid (rt_valid),
      .out_side  (rt_side),
      .out_smag  (rt_smag),
      .out_len   (rt_len)
   );

   fnu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid),
      .in_side   (rt_side),
      .in_smag   (rt_smag),
      .in_len    (rt_len),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   always_comb begin
      logic [QW-1:0] q_clip;
      logic [OW-1:0] comp [3];
      for (int j = 0; j < 3; j++) begin
         q_clip  = (dv_quo[j] > QUO_LIMIT) ? QUO_LIMIT : dv_quo[j];
         comp[j] = dv_side.neg[j] ? OW'(-OW'(q_clip)) : OW'(q_clip);
      end
      pipe_v              = dv_valid;
      pipe_d.degenerate   = dv_side.degen;
      pipe_d.face_out     = dv_side.tag.face;
      pipe_d.last_out     = dv_side.tag.last;
      if (dv_side.degen) begin
         pipe_d.normal_x = '0;
         pipe_d.normal_y = '0;
         pipe_d.normal_z = fnu_pkg::UNIT_ONE;
      end else begin
         pipe_d.normal_x = comp[0];
         pipe_d.normal_y = comp[1];
         pipe_d.normal_z = comp[2];
      end
   end

   // output register with a one-entry skid buffer
   assign take = !out_v_ff || rsp_chan.ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (take) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = en && pipe_v;
            out_d_in = pipe_d;
         end
      end else if (en && pipe_v) begin
         skid_v_in = 1'b1;
         skid_d_in = pipe_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.payload = out_d_ff;

   `FNU_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff)
   `FNU_ASSERT_NXT(a_stall_fills_skid, clock, reset, out_v_ff && !rsp_chan.ready && !skid_v_ff && pipe_v, skid_v_ff)
   `FNU_ASSERT_IMP(a_degen_unit_z, clock, reset, out_v_ff && out_d_ff.degenerate, out_d_ff.normal_x == '0 && out_d_ff.normal_y == '0 && out_d_ff.normal_z == fnu_pkg::UNIT_ONE)
   `FNU_ASSERT_IMP(a_norm_bounded, clock, reset, out_v_ff, out_d_ff.normal_x <= fnu_pkg::UNIT_ONE && out_d_ff.normal_x >= -fnu_pkg::UNIT_ONE && out_d_ff.normal_z <= fnu_pkg::UNIT_ONE)

endmodule

`default_nettype wire

// File: src/fnu_ram.sv
`default_nettype none

module fnu_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 4096
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]                            wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                                 rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/fnu_cross.sv
`default_nettype none

// edge vectors, cross product and component magnitudes, four stages
module fnu_cross (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire fnu_pkg::tag_type     in_tag,
   input  wire fnu_pkg::vertex_type  vert_a,
   input  wire fnu_pkg::vertex_type  vert_b,
   input  wire fnu_pkg::vertex_type  vert_c,
   output logic                      out_valid,
   output fnu_pkg::tag_type          out_tag,
   output fnu_pkg::mag_vec_type      out_mag,
   output logic [2:0]                out_neg
);

   localparam int EW = fnu_pkg::EDGE_W;
   localparam int PW = fnu_pkg::PROD_W;
   localparam int MW = fnu_pkg::MAG_W;

   logic              v_ff   [4];
   fnu_pkg::tag_type  tag_ff [4];

   logic signed [EW-1:0] e1_in [3];
   logic signed [EW-1:0] e2_in [3];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [PW-1:0] p_in  [6];
   logic signed [PW-1:0] p_ff  [6];
   logic signed [PW-1:0] n_in  [3];
   logic signed [PW-1:0] n_ff  [3];
   fnu_pkg::mag_vec_type mag_in;
   fnu_pkg::mag_vec_type mag_ff;
   logic [2:0]           neg_in;
   logic [2:0]           neg_ff;

   always_comb begin
      e1_in[0] = EW'(vert_a.x) - EW'(vert_b.x);
      e1_in[1] = EW'(vert_a.y) - EW'(vert_b.y);
      e1_in[2] = EW'(vert_a.z) - EW'(vert_b.z);
      e2_in[0] = EW'(vert_c.x) - EW'(vert_b.x);
      e2_in[1] = EW'(vert_c.y) - EW'(vert_b.y);
      e2_in[2] = EW'(vert_c.z) - EW'(vert_b.z);
   end

   always_comb begin
      p_in[0] = PW'(e1_ff[1]) * PW'(e2_ff[2]);
      p_in[1] = PW'(e1_ff[2]) * PW'(e2_ff[1]);
      p_in[2] = PW'(e1_ff[2]) * PW'(e2_ff[0]);
      p_in[3] = PW'(e1_ff[0]) * PW'(e2_ff[2]);
      p_in[4] = PW'(e1_ff[0]) * PW'(e2_ff[1]);
      p_in[5] = PW'(e1_ff[1]) * PW'(e2_ff[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = p_ff[2*i] - p_ff[2*i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = n_ff[i][PW-1];
         mag_in[i] = neg_in[i] ? MW'(-n_ff[i]) : MW'(n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < 4; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         p_ff   <= p_in;
         n_ff   <= n_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_tag   = tag_ff[3];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

`default_nettype wire

// File: src/fnu_scale.sv
`default_nettype none

// degenerate test and normalising shift, then sum of squares, five stages
module fnu_scale (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire fnu_pkg::tag_type                  in_tag,
   input  wire fnu_pkg::mag_vec_type              in_mag,
   input  wire logic [2:0]                        in_neg,
   input  wire logic [fnu_pkg::LIMIT_W-1:0]       min_length,
   output logic                                   out_valid,
   output fnu_pkg::norm_side_type                 out_side,
   output fnu_pkg::smag_vec_type                  out_smag,
   output logic [fnu_pkg::SUM_W-1:0]              out_sum
);

   localparam int MW  = fnu_pkg::MAG_W;
   localparam int LW  = fnu_pkg::SMALL_W;
   localparam int HW  = fnu_pkg::SHIFT_W;
   localparam int SW  = fnu_pkg::SMAG_W;
   localparam int QW  = fnu_pkg::SQ_W;
   localparam int UW  = fnu_pkg::SUM_W;
   localparam int LSW = 2 * LW;
   localparam int ACW = 2 * LW + 2;
   localparam int WIDE_W = MW + SW - 1;
   localparam logic [HW-1:0] TOP_POS = HW'(SW - 1);

   logic              v_ff   [5];
   fnu_pkg::tag_type  tag_ff [5];
   logic [2:0]        neg_ff [5];

   // stage 1
   fnu_pkg::mag_vec_type mag1_ff;
   logic [MW-1:0]        m_in;
   logic [MW-1:0]        m_ff;
   // stage 2
   fnu_pkg::mag_vec_type mag2_ff;
   logic [HW-1:0]        pos_in;
   logic [HW-1:0]        pos_ff;
   logic                 zero_ff;
   logic                 big_ff;
   logic [LSW-1:0]       sq_in  [3];
   logic [LSW-1:0]       sq_ff  [3];
   logic [LSW-1:0]       lim_ff;
   // stage 3
   logic [ACW-1:0]       acc_in;
   logic                 degen_in;
   logic                 degen_ff [3];
   fnu_pkg::smag_vec_type smag_in;
   fnu_pkg::smag_vec_type smag3_ff;
   // stage 4
   logic [QW-1:0]        sq2_ff [3];
   fnu_pkg::smag_vec_type smag4_ff;
   // stage 5
   logic [UW-1:0]        sum_ff;
   fnu_pkg::smag_vec_type smag5_ff;

   always_comb begin
      m_in = in_mag[0];
      if (in_mag[1] > m_in) begin
         m_in = in_mag[1];
      end
      if (in_mag[2] > m_in) begin
         m_in = in_mag[2];
      end
   end

   // position of the leading one of the largest magnitude, and squares of the low 16 bits of each magnitude
   always_comb begin
      pos_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (m_ff[i]) begin
            pos_in = HW'(i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = LSW'(mag1_ff[i][LW-1:0]) * LSW'(mag1_ff[i][LW-1:0]);
      end
   end

   always_comb begin
      logic [WIDE_W-1:0] wide;
      wide     = '0;
      acc_in   = ACW'(sq_ff[0]) + ACW'(sq_ff[1]) + ACW'(sq_ff[2]);
      degen_in = zero_ff || (!big_ff && (acc_in < ACW'(lim_ff)));
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= TOP_POS) begin
            smag_in[i] = SW'(mag2_ff[i] >> (pos_ff - TOP_POS));
         end else begin
            wide       = WIDE_W'(mag2_ff[i]) << (TOP_POS - pos_ff);
            smag_in[i] = wide[SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < 5; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         neg_ff[0] <= in_neg;
         for (int i = 1; i < 5; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         mag1_ff <= in_mag;
         m_ff    <= m_in;

         mag2_ff <= mag1_ff;
         pos_ff  <= pos_in;
         zero_ff <= (m_ff == '0);
         big_ff  <= |m_ff[MW-1:LW];
         sq_ff   <= sq_in;
         lim_ff  <= LSW'(min_length) * LSW'(min_length);

         degen_ff[0] <= degen_in;
         degen_ff[1] <= degen_ff[0];
         degen_ff[2] <= degen_ff[1];
         smag3_ff    <= smag_in;

         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= QW'(smag3_ff[i]) * QW'(smag3_ff[i]);
         end
         smag4_ff <= smag3_ff;

         sum_ff   <= UW'(sq2_ff[0]) + UW'(sq2_ff[1]) + UW'(sq2_ff[2]);
         smag5_ff <= smag4_ff;
      end
   end

   assign out_valid       = v_ff[4];
   assign out_side.tag    = tag_ff[4];
   assign out_side.degen  = degen_ff[2];
   assign out_side.neg    = neg_ff[4];
   assign out_smag        = smag5_ff;
   assign out_sum         = sum_ff;

endmodule

`default_nettype wire

// File: src/fnu_isqrt.sv
`default_nettype none

// integer square root, one result bit per stage
module fnu_isqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire fnu_pkg::norm_side_type         in_side,
   input  wire fnu_pkg::smag_vec_type          in_smag,
   input  wire logic [fnu_pkg::SUM_W-1:0]      in_sum,
   output logic                                out_valid,
   output fnu_pkg::norm_side_type              out_side,
   output fnu_pkg::smag_vec_type               out_smag,
   output logic [fnu_pkg::LEN_W-1:0]           out_len
);

   localparam int STEPS = fnu_pkg::ROOT_STEPS;
   localparam int UW    = fnu_pkg::SUM_W;
   localparam int LW    = fnu_pkg::LEN_W;

   logic                   v_ff    [STEPS];
   logic [UW-1:0]          s_ff    [STEPS];
   logic [UW-1:0]          r_ff    [STEPS];
   fnu_pkg::norm_side_type side_ff [STEPS];
   fnu_pkg::smag_vec_type  smag_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [UW-1:0] STEP_BIT = UW'(1) << (2 * (STEPS - 1 - k));

      logic                   v_src;
      logic [UW-1:0]          s_src;
      logic [UW-1:0]          r_src;
      fnu_pkg::norm_side_type side_src;
      fnu_pkg::smag_vec_type  smag_src;
      logic [UW-1:0]          trial;
      logic [UW-1:0]          s_in;
      logic [UW-1:0]          r_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign s_src    = in_sum;
         assign r_src    = '0;
         assign side_src = in_side;
         assign smag_src = in_smag;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign s_src    = s_ff[k-1];
         assign r_src    = r_ff[k-1];
         assign side_src = side_ff[k-1];
         assign smag_src = smag_ff[k-1];
      end

      always_comb begin
         trial = r_src + STEP_BIT;
         if (s_src >= trial) begin
            s_in = s_src - trial;
            r_in = (r_src >> 1) + STEP_BIT;
         end else begin
            s_in = s_src;
            r_in = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k]    <= s_in;
            r_ff[k]    <= r_in;
            side_ff[k] <= side_src;
            smag_ff[k] <= smag_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
   assign out_smag  = smag_ff[STEPS-1];
   assign out_len   = r_ff[STEPS-1][LW-1:0];

endmodule

`default_nettype wire

// File: src/fnu_div.sv
`default_nettype none

// three restoring dividers side by side, one quotient bit per stage
module fnu_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire fnu_pkg::norm_side_type      in_side,
   input  wire fnu_pkg::smag_vec_type       in_smag,
   input  wire logic [fnu_pkg::LEN_W-1:0]   in_len,
   output logic                             out_valid,
   output fnu_pkg::norm_side_type           out_side,
   output fnu_pkg::quo_vec_type             out_quo
);

   localparam int STEPS = fnu_pkg::QUO_W;
   localparam int NW    = fnu_pkg::NUM_W;
   localparam int LW    = fnu_pkg::LEN_W;
   localparam int FW    = fnu_pkg::FRAC_W;

   logic                   v_ff    [STEPS];
   logic [2:0][NW-1:0]     rem_ff  [STEPS];
   fnu_pkg::quo_vec_type   q_ff    [STEPS];
   logic [LW-1:0]          len_ff  [STEPS];
   fnu_pkg::norm_side_type side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int SH = STEPS - 1 - k;

      logic                   v_src;
      logic [2:0][NW-1:0]     rem_src;
      fnu_pkg::quo_vec_type   q_src;
      logic [LW-1:0]          len_src;
      fnu_pkg::norm_side_type side_src;
      logic [NW-1:0]          divisor;
      logic [2:0][NW-1:0]     rem_in;
      fnu_pkg::quo_vec_type   q_in;

      if (k == 0) begin : g_first
         // numerator carries half the divisor so the quotient rounds to nearest
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign rem_src[j] = (NW'(in_smag[j]) << FW) + NW'(in_len >> 1);
         end
         assign v_src    = in_valid;
         assign q_src    = '0;
         assign len_src  = in_len;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
         assign len_src  = len_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         divisor = NW'(len_src) << SH;
         rem_in  = rem_src;
         q_in    = q_src;
         for (int j = 0; j < 3; j++) begin
            if (rem_src[j] >= divisor) begin
               rem_in[j]  = rem_src[j] - divisor;
               q_in[j][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            len_ff[k]  <= len_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
   assign out_quo   = q_ff[STEPS-1];

endmodule

`default_nettype wire

// File: bench/fnu_normal_checker.sv
`default_nettype none

module fnu_normal_checker
   import fnu_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_payload_type      req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_payload_type      rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [LIMIT_W-1:0]   csr_wr_data,
   output int                        fail_count,
   output int                        pending
);

   vertex_type          vertices [4096];
   logic [LIMIT_W-1:0]  min_len = MIN_LENGTH_RESET;
   rsp_payload_type     normals_due [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic rsp_payload_type face_normal(vertex_type va, vertex_type vb,
                                                   vertex_type vc, logic [LIMIT_W-1:0] lim,
                                                   logic [IDX_W-1:0] face, logic last);
      longint          pa [3];
      longint          pb [3];
      longint          pc [3];
      longint          e1 [3];
      longint          e2 [3];
      longint          n [3];
      logic [63:0]     mag [3];
      logic [63:0]     m;
      logic [63:0]     sq;
      logic [63:0]     rem;
      logic [63:0]     root;
      logic [63:0]     bitv;
      logic [63:0]     q;
      logic [2:0]      neg;
      logic            degen;
      rsp_payload_type r;
      int              i;
      pa = '{va.x, va.y, va.z};
      pb = '{vb.x, vb.y, vb.z};
      pc = '{vc.x, vc.y, vc.z};
      for (i = 0; i < 3; i++) begin
         e1[i] = pa[i] - pb[i];
         e2[i] = pc[i] - pb[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (i = 0; i < 3; i++) begin
         neg[i] = n[i] < 0;
         mag[i] = neg[i] ? -n[i] : n[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) degen = 1'b1;
      else if (m >= 64'd65536) degen = 1'b0;
      else begin
         sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         degen = sq < 64'(lim) * 64'(lim);
      end
      r.face_out = face;
      r.last_out = last;
      r.degenerate = degen;
      if (degen) begin
         r.normal_x = '0;
         r.normal_y = '0;
         r.normal_z = UNIT_ONE;
      end else begin
         // bring the largest magnitude into [2^29, 2^30)
         while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         rem = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > rem) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else root = root >> 1;
            bitv = bitv >> 2;
         end
         for (i = 0; i < 3; i++) begin
            q = ((mag[i] << 14) + (root >> 1)) / root;
            if (q > 64'd16384) q = 64'd16384;
            if (neg[i]) q = -q;
            case (i)
               0: r.normal_x = q[15:0];
               1: r.normal_y = q[15:0];
               default: r.normal_z = q[15:0];
            endcase
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (normals_due.size() == 0) begin
               $display("%0t: unexpected normal %p", $time, rsp_payload);
               fail_count++;
            end else begin
               want = normals_due.pop_front();
               if (rsp_payload.normal_x !== want.normal_x ||
                   rsp_payload.normal_y !== want.normal_y ||
                   rsp_payload.normal_z !== want.normal_z ||
                   rsp_payload.degenerate !== want.degenerate ||
                   rsp_payload.face_out !== want.face_out ||
                   rsp_payload.last_out !== want.last_out) begin
                  $display("%0t: normal mismatch expected %p actual %p",
                           $time, want, rsp_payload);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.operation == OP_WRITE)
               vertices[req_payload.vertex_slot] =
                  '{req_payload.pos_x, req_payload.pos_y, req_payload.pos_z};
            else
               normals_due.push_back(face_normal(vertices[req_payload.corner_a],
                                                 vertices[req_payload.corner_b],
                                                 vertices[req_payload.corner_c],
                                                 min_len, req_payload.face_number,
                                                 req_payload.last_face));
         end
         if (csr_wr_en) min_len = csr_wr_data;
      end
      pending = normals_due.size();
   end

endmodule

`default_nettype wire

// File: bench/tb_face_normal_unit_core.sv
`default_nettype none

module tb_face_normal_unit_core;
   import fnu_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;
   int                  fail_count;
   int                  pending;
   int                  tx_idle_pct = 0;
   int                  rx_idle_pct = 0;
   bit                  hold_armed = 1'b0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;
   bit                  slot_written [4096];
   int                  written_slots [$];

   fnu_stream_if #(.payload_type(req_payload_type)) req_if ();
   fnu_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   face_normal_unit_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fnu_normal_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left = 400;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_request(req_payload_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic write_vertex(int slot, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_payload_type item;
      item = req_payload_type'({$urandom, $urandom, $urandom});
      item.operation = OP_WRITE;
      item.vertex_slot = IDX_W'(slot);
      item.pos_x = x;
      item.pos_y = y;
      item.pos_z = z;
      if (!slot_written[slot]) begin
         slot_written[slot] = 1'b1;
         written_slots.push_back(slot);
      end
      send_request(item);
   endtask

   task automatic face_request(int a, int b, int c);
      req_payload_type item;
      item = req_payload_type'({$urandom, $urandom, $urandom});
      item.operation = OP_FACE;
      item.corner_a = IDX_W'(a);
      item.corner_b = IDX_W'(b);
      item.corner_c = IDX_W'(c);
      send_request(item);
   endtask

   function automatic logic [15:0] rand_coord();
      if ($urandom_range(1)) return 16'($urandom);
      return 16'($signed($urandom_range(16)) - 8);
   endfunction

   function automatic int pick_slot();
      return written_slots[$urandom_range(written_slots.size() - 1)];
   endfunction

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_min_length(logic [LIMIT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_requests(int count);
      int a;
      int b;
      int c;
      repeat (count) begin
         if ($urandom_range(99) < 35)
            write_vertex($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
         else begin
            a = pick_slot();
            b = pick_slot();
            c = pick_slot();
            // coincident corners now and then
            case ($urandom_range(9))
               0: a = b;
               1: c = b;
               2: c = a;
               default: ;
            endcase
            face_request(a, b, c);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_vertex(0, 16'sd0, 16'sd0, 16'sd0);
      write_vertex(1, 16'sd256, 16'sd0, 16'sd0);
      write_vertex(2, 16'sd0, 16'sd256, 16'sd0);
      write_vertex(3, -16'sd32768, 16'sd32767, -16'sd32768);
      write_vertex(4095, 16'sd32767, -16'sd32768, 16'sd32767);
      write_vertex(5, 16'sd1, 16'sd0, 16'sd0);
      write_vertex(6, 16'sd0, 16'sd1, 16'sd0);
      write_vertex(7, -16'sd1, -16'sd1, 16'sd5);
      face_request(1, 0, 2);
      face_request(2, 0, 1);
      face_request(4095, 3, 0);
      face_request(3, 4095, 7);
      face_request(5, 0, 6);
      face_request(0, 1, 1);
      face_request(1, 1, 2);
      face_request(5, 7, 5);
      wait_drained();
      set_min_length('0);
      face_request(0, 1, 1);
      face_request(5, 0, 6);
      face_request(4095, 3, 7);

      tx_idle_pct = 35;
      rx_idle_pct = 86;
      random_requests(450);
      wait_drained();
      set_min_length('1);
      tx_idle_pct = 86;
      rx_idle_pct = 35;
      random_requests(350);
      wait_drained();
      set_min_length(LIMIT_W'($urandom_range(1, 65534)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_armed = 1'b1;
      random_requests(350);
      wait_drained();
      set_min_length(16'd1);
      random_requests(350);
      wait_drained();

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
